// ----- rtl/alist_pkg.sv -----
// ----------------------------------------------------------------------------
// alist_pkg: shared types and constants for the array list engine
// Sizes of the entry store, request and status codes, and the register map
// of the configuration port.
// ----------------------------------------------------------------------------
package alist_pkg;

    // Entry store geometry
    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = CW + 1;

    // Fixed field widths
    localparam int REQ_W  = 3;
    localparam int POS_W  = 4;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;
    localparam int CAP_W  = 5;

    // Common width for mixed count / position / capacity compares
    localparam int XW = ((CW > POS_W) ? ((CW > CAP_W) ? CW : CAP_W)
                                      : ((POS_W > CAP_W) ? POS_W : CAP_W)) + 1;

    // Configuration port
    localparam int                  PADDR_W      = 3;
    localparam int                  PDATA_W      = 32;
    localparam logic [PADDR_W-3:0]  REG_CAPACITY = '0;
    localparam logic [CAP_W-1:0]    CAP_RESET    = CAP_W'(16);

    // Request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND  = 3'd0,
        REQ_INSERT  = 3'd1,
        REQ_DELETE  = 3'd2,
        REQ_LSEARCH = 3'd3,
        REQ_BSEARCH = 3'd4,
        REQ_SORTED  = 3'd5
    } t_req;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

endpackage

// ----- rtl/alist_cfg.sv -----
// ----------------------------------------------------------------------------
// alist_cfg: configuration register block
// APB-style slave holding the capacity register. Zero-wait, always ready.
// ----------------------------------------------------------------------------
module alist_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [alist_pkg::PADDR_W-1:0]  paddr,
    input  logic [alist_pkg::PDATA_W-1:0]  pwdata,
    output logic [alist_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready,
    output logic [alist_pkg::CAP_W-1:0]    o_capacity
);
    import alist_pkg::*;

    logic              w_wr;
    logic              w_sel_cap;
    logic [CAP_W-1:0]  r_capacity;

    // Decode the word index of the access
    assign w_sel_cap = (paddr[PADDR_W-1:2] == REG_CAPACITY);
    assign w_wr      = psel & penable & pwrite;

    // Capture capacity on the access phase of a write transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (w_wr && w_sel_cap) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    // Return register contents, zero elsewhere
    assign prdata     = w_sel_cap ? PDATA_W'(r_capacity) : '0;
    assign pready     = 1'b1;
    assign o_capacity = r_capacity;

endmodule

// ----- rtl/array_list_engine.sv -----
// ----------------------------------------------------------------------------
// array_list_engine: packed list of signed words with a live count
// Append, insert at, delete at, move-to-front linear search, binary search
// and sorted insert over a single-port-read entry memory.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+------------------------------
//   cfg     | in        | psel/penable/pwrite     | paddr, pwdata -> prdata
//   in      | in        | i_in_valid/o_in_ready   | req_type, position, data_value
//   out     | out       | o_out_valid/i_out_ready | status, found_position,
//           |           |                         | data_out, count_out
//
// One request at a time: a new request is taken only once the last result has gone
// to the output register. Insert, delete and sorted insert move entries one at a time
// (sorted insert stops on a word not greater than the key); linear search probes from
// the front and swaps a hit to the head; binary search bisects the live range. Reset
// clears the count; the entry memory needs no clearing. A stalled result waits in the
// output register while the next request is worked on.
// ----------------------------------------------------------------------------
module array_list_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [alist_pkg::PADDR_W-1:0]  paddr,
    input  logic [alist_pkg::PDATA_W-1:0]  pwdata,
    output logic [alist_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [alist_pkg::REQ_W-1:0]    i_req_type,
    input  logic [alist_pkg::POS_W-1:0]    i_position,
    input  logic signed [alist_pkg::DATA_W-1:0] i_data_value,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [alist_pkg::STAT_W-1:0]   o_status,
    output logic [alist_pkg::POS_W-1:0]    o_found_position,
    output logic signed [alist_pkg::DATA_W-1:0] o_data_out,
    output logic [alist_pkg::CNT_W-1:0]    o_count_out
);
    import alist_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OPEN,
        S_MOVE,
        S_DGET,
        S_DSHIFT,
        S_DMOVE,
        S_LREAD,
        S_LCMP,
        S_FRONT,
        S_FRONT2,
        S_BPROBE,
        S_BCMP,
        S_DONE
    } t_state;

    // Sequencer registers
    t_state                    r_state, n_state;
    logic [REQ_W-1:0]          r_req, n_req;
    logic [POS_W-1:0]          r_pos, n_pos;
    logic signed [DATA_W-1:0]  r_key, n_key;
    logic [CW-1:0]             r_at, n_at;
    logic signed [SW-1:0]      r_lo, n_lo;
    logic signed [SW-1:0]      r_hi, n_hi;
    logic [AW-1:0]             r_hit, n_hit;
    logic [STAT_W-1:0]         r_status, n_status;
    logic [POS_W-1:0]          r_fpos, n_fpos;
    logic signed [DATA_W-1:0]  r_dout, n_dout;
    logic [CW-1:0]             r_count, n_count;

    // Result register
    logic                      r_out_valid;
    logic [STAT_W-1:0]         r_o_status;
    logic [POS_W-1:0]          r_o_fpos;
    logic signed [DATA_W-1:0]  r_o_dout;
    logic [CNT_W-1:0]          r_o_count;

    // Entry memory ports
    logic signed [DATA_W-1:0]  r_mem [DEPTH];
    logic signed [DATA_W-1:0]  r_rdata;
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic signed [DATA_W-1:0]  w_wdata;
    logic                      w_re;
    logic [AW-1:0]             w_raddr;

    // Misc
    logic [CAP_W-1:0]          w_capacity;
    logic [XW-1:0]             w_eff_cap;
    logic                      w_full;
    logic                      w_eq;
    logic                      w_gt;
    logic signed [SW:0]        w_sum;
    logic signed [SW:0]        w_mid;
    logic                      w_load;

    // Configuration registers
    alist_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (w_capacity)
    );

    // Clamp capacity to the store depth and test for a full list
    assign w_eff_cap = (XW'(w_capacity) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(w_capacity);
    assign w_full    = (XW'(r_count) >= w_eff_cap);

    // Shared comparator: memory word against the key
    assign w_eq = (r_rdata == r_key);
    assign w_gt = (r_rdata > r_key);

    // Bisection midpoint
    assign w_sum = {r_lo[SW-1], r_lo} + {r_hi[SW-1], r_hi};
    assign w_mid = w_sum >>> 1;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Sequencer next-state logic
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_pos    = r_pos;
        n_key    = r_key;
        n_at     = r_at;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_hit    = r_hit;
        n_status = r_status;
        n_fpos   = r_fpos;
        n_dout   = r_dout;
        n_count  = r_count;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_wdata  = r_key;
        w_re     = 1'b0;
        w_raddr  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req    = i_req_type;
                    n_pos    = i_position;
                    n_key    = i_data_value;
                    n_status = ST_OK;
                    n_fpos   = '0;
                    n_dout   = '0;
                    n_at     = r_count;
                    n_state  = S_DONE;
                    case (i_req_type)
                        REQ_APPEND: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_count[AW-1:0];
                                w_wdata = i_data_value;
                                n_fpos  = POS_W'(r_count);
                                n_count = r_count + CW'(1);
                            end
                        end
                        REQ_INSERT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else if (XW'(i_position) > XW'(r_count)) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_state = S_OPEN;
                            end
                        end
                        REQ_SORTED: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_pos   = '0;
                                n_state = S_OPEN;
                            end
                        end
                        REQ_DELETE: begin
                            if (XW'(i_position) >= XW'(r_count)) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_at    = CW'(i_position);
                                w_re    = 1'b1;
                                w_raddr = AW'(i_position);
                                n_state = S_DGET;
                            end
                        end
                        REQ_LSEARCH: begin
                            n_at    = '0;
                            n_state = S_LREAD;
                        end
                        REQ_BSEARCH: begin
                            n_lo    = '0;
                            n_hi    = {1'b0, r_count} - SW'(1);
                            n_state = S_BPROBE;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Open a gap: fetch the entry below the hole, or drop the key in
            S_OPEN: begin
                if (XW'(r_at) > XW'(r_pos)) begin
                    w_re    = 1'b1;
                    w_raddr = AW'(r_at - CW'(1));
                    n_state = S_MOVE;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_at[AW-1:0];
                    n_fpos  = POS_W'(r_at);
                    n_count = r_count + CW'(1);
                    n_state = S_DONE;
                end
            end

            // Shift the fetched entry up; sorted insert stops at a word not greater than the key
            S_MOVE: begin
                w_we    = 1'b1;
                w_waddr = r_at[AW-1:0];
                if (r_req == REQ_INSERT || w_gt) begin
                    w_wdata = r_rdata;
                    n_at    = r_at - CW'(1);
                    n_state = S_OPEN;
                end else begin
                    n_fpos  = POS_W'(r_at);
                    n_count = r_count + CW'(1);
                    n_state = S_DONE;
                end
            end

            // Capture the removed word
            S_DGET: begin
                n_dout  = r_rdata;
                n_state = S_DSHIFT;
            end

            // Close the gap one entry at a time
            S_DSHIFT: begin
                if (XW'(r_at) + XW'(1) < XW'(r_count)) begin
                    w_re    = 1'b1;
                    w_raddr = AW'(r_at + CW'(1));
                    n_state = S_DMOVE;
                end else begin
                    n_fpos  = r_pos;
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end

            S_DMOVE: begin
                w_we    = 1'b1;
                w_waddr = r_at[AW-1:0];
                w_wdata = r_rdata;
                n_at    = r_at + CW'(1);
                n_state = S_DSHIFT;
            end

            // Linear scan from the front
            S_LREAD: begin
                if (r_at < r_count) begin
                    w_re    = 1'b1;
                    w_raddr = r_at[AW-1:0];
                    n_state = S_LCMP;
                end else begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_DONE;
                end
            end

            S_LCMP: begin
                if (w_eq) begin
                    n_hit   = r_at[AW-1:0];
                    w_re    = 1'b1;
                    w_raddr = '0;
                    n_state = S_FRONT;
                end else begin
                    n_at    = r_at + CW'(1);
                    n_state = S_LREAD;
                end
            end

            // Move to front: old head goes to the hit slot, key to the head
            S_FRONT: begin
                w_we    = 1'b1;
                w_waddr = r_hit;
                w_wdata = r_rdata;
                n_state = S_FRONT2;
            end

            S_FRONT2: begin
                w_we    = 1'b1;
                w_waddr = '0;
                n_fpos  = '0;
                n_state = S_DONE;
            end

            // Bisection probe
            S_BPROBE: begin
                if (r_lo <= r_hi) begin
                    n_at    = w_mid[CW-1:0];
                    w_re    = 1'b1;
                    w_raddr = w_mid[AW-1:0];
                    n_state = S_BCMP;
                end else begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_DONE;
                end
            end

            S_BCMP: begin
                if (w_eq) begin
                    n_fpos  = POS_W'(r_at);
                    n_state = S_DONE;
                end else begin
                    if (w_gt) begin
                        n_hi = {1'b0, r_at} - SW'(1);
                    end else begin
                        n_lo = {1'b0, r_at} + SW'(1);
                    end
                    n_state = S_BPROBE;
                end
            end

            // Hand the result to the output register
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold sequencer state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_req    <= n_req;
        r_pos    <= n_pos;
        r_key    <= n_key;
        r_at     <= n_at;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_hit    <= n_hit;
        r_status <= n_status;
        r_fpos   <= n_fpos;
        r_dout   <= n_dout;
        if (w_load) begin
            r_o_status <= r_status;
            r_o_fpos   <= r_fpos;
            r_o_dout   <= r_dout;
            r_o_count  <= CNT_W'(r_count);
        end
    end

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_found_position = r_o_fpos;
    assign o_data_out       = r_o_dout;
    assign o_count_out      = r_o_count;

endmodule
